FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Synthesis builds see empty bodies; simulation builds get concurrent checks
// clocked by aclk and disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge
`define LFPS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("lfps: invariant violated");

// consequent holds in the same cycle as the antecedent
`define LFPS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lfps: same-cycle implication violated");

// consequent holds in the cycle after the antecedent
`define LFPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lfps: next-cycle implication violated");

`else

`define LFPS_ASSERT_ALWAYS(lbl, expr)
`define LFPS_ASSERT_IMPLY(lbl, ante, cons)
`define LFPS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: rtl/lfps_pkg.sv
`timescale 1ns / 1ps

package lfps_pkg;

    // payload widths
    localparam int SENSOR_W = 5;
    localparam int STEER_W  = 16;
    localparam int CLASS_W  = 3;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 14;
    localparam int LIMIT_W    = 12;

    // internal arithmetic widths
    localparam int ERR_W   = 13;
    localparam int INTEG_W = 18;
    localparam int DERIV_W = 14;
    localparam int ACC_W   = 32;
    localparam int MUL_W   = GAIN_W + 1 + INTEG_W;

    // steering divide: 1600 = 64 * 25, a shift for 64, a reciprocal multiply for 25
    localparam int DIVISOR     = 1600;
    localparam int QUOT_W      = 15;
    localparam int PRE_SHIFT   = 6;
    localparam int SCALED_W    = 20;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 25;
    localparam int RPROD_W     = SCALED_W + RECIP_W;
    localparam longint SAT_MAG_VAL = longint'(DIVISOR) * (longint'(1) << QUOT_W);

    typedef logic        [SENSOR_W-1:0]  sensors_t;
    typedef logic signed [STEER_W-1:0]   steer_t;
    typedef logic        [CLASS_W-1:0]   class_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic        [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic        [GAIN_W-1:0]    gain_t;
    typedef logic        [LIMIT_W-1:0]   limit_t;
    typedef logic signed [ERR_W-1:0]     err_t;
    typedef logic signed [INTEG_W-1:0]   integ_t;
    typedef logic signed [DERIV_W-1:0]   deriv_t;
    typedef logic signed [ACC_W-1:0]     acc_t;
    typedef logic        [QUOT_W-1:0]    quot_t;
    typedef logic        [SCALED_W-1:0]  scaled_t;
    typedef logic        [RECIP_W-1:0]   recip_t;
    typedef logic        [RPROD_W-1:0]   rprod_t;
    typedef logic        [1:0]           mul_sel_t;

    localparam acc_t   SAT_MAG  = ACC_W'(SAT_MAG_VAL);
    // ceil(2^25 / 25): exact quotient for every scaled magnitude below 2^20
    localparam recip_t RECIP_25 = 21'd1342178;
    localparam steer_t STEER_MAX = 16'sh7FFF;
    localparam steer_t STEER_MIN = 16'sh8000;

    // register indexes
    localparam cfg_idx_t REG_GAIN_PROP      = 4'd0;
    localparam cfg_idx_t REG_GAIN_INTEG     = 4'd1;
    localparam cfg_idx_t REG_GAIN_DERIV     = 4'd2;
    localparam cfg_idx_t REG_INTEGRAL_LIMIT = 4'd3;
    localparam limit_t   LIMIT_RESET        = 12'd1000;

    // pattern classes
    localparam class_t CLS_ALL_BLACK = 3'd0;
    localparam class_t CLS_ALL_WHITE = 3'd1;
    localparam class_t CLS_CENTER    = 3'd2;
    localparam class_t CLS_SLIGHT    = 3'd3;
    localparam class_t CLS_STRONG    = 3'd4;
    localparam class_t CLS_WEIGHTED  = 3'd5;

    // voted patterns with fixed handling
    localparam sensors_t PAT_ALL_BLACK = 5'h1F;
    localparam sensors_t PAT_ALL_WHITE = 5'h00;
    localparam sensors_t PAT_CENTER    = 5'h04;
    localparam sensors_t PAT_SLIGHT_L  = 5'h06;
    localparam sensors_t PAT_SLIGHT_R  = 5'h0C;
    localparam sensors_t PAT_LEFT3     = 5'h07;
    localparam sensors_t PAT_RIGHT3    = 5'h1C;
    localparam sensors_t PAT_LEFT2     = 5'h03;
    localparam sensors_t PAT_RIGHT2    = 5'h18;

    // fixed errors in sixteenths
    localparam err_t ERR_SLIGHT = 13'sd1000;
    localparam err_t ERR_STRONG = 13'sd2000;

    // multiplier operand select
    localparam mul_sel_t MUL_SEL_P = 2'd0;
    localparam mul_sel_t MUL_SEL_I = 2'd1;
    localparam mul_sel_t MUL_SEL_D = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic     accept;
        logic     classify;
        logic     integrate;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_add;
        logic     div_init;
        logic     div_step;
        logic     out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;
        logic out_free;
    } status_t;

    // mean sensor weight over the lit sensors, truncated toward zero
    function automatic err_t weighted_error(input sensors_t pat);
        err_t e;
        case (pat)
            5'h01:   e = -13'sd3200;
            5'h02:   e = -13'sd1600;
            5'h03:   e = -13'sd2400;
            5'h05:   e = -13'sd1600;
            5'h06:   e = -13'sd800;
            5'h07:   e = -13'sd1600;
            5'h08:   e = 13'sd1600;
            5'h09:   e = -13'sd800;
            5'h0B:   e = -13'sd1066;
            5'h0C:   e = 13'sd800;
            5'h0D:   e = -13'sd533;
            5'h0F:   e = -13'sd800;
            5'h10:   e = 13'sd3200;
            5'h12:   e = 13'sd800;
            5'h13:   e = -13'sd533;
            5'h14:   e = 13'sd1600;
            5'h16:   e = 13'sd533;
            5'h17:   e = -13'sd400;
            5'h18:   e = 13'sd2400;
            5'h19:   e = 13'sd533;
            5'h1A:   e = 13'sd1066;
            5'h1C:   e = 13'sd1600;
            5'h1D:   e = 13'sd400;
            5'h1E:   e = 13'sd800;
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/lfps_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfps_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lfps_pkg::status_t status,
    output lfps_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_CLASS    = 4'd1;
    localparam logic [3:0] ST_INTEG    = 4'd2;
    localparam logic [3:0] ST_MUL_P    = 4'd3;
    localparam logic [3:0] ST_MUL_I    = 4'd4;
    localparam logic [3:0] ST_MUL_D    = 4'd5;
    localparam logic [3:0] ST_ACC_D    = 4'd6;
    localparam logic [3:0] ST_DIV_INIT = 4'd7;
    localparam logic [3:0] ST_DIV      = 4'd8;
    localparam logic [3:0] ST_OUT      = 4'd9;

    logic [3:0] state_reg, state_next;

    // sequence one item through the datapath
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS: begin
                cmd.classify = 1'b1;
                state_next   = ST_INTEG;
            end
            ST_INTEG: begin
                cmd.integrate = 1'b1;
                state_next    = status.skip ? ST_OUT : ST_MUL_P;
            end
            ST_MUL_P: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lfps_pkg::MUL_SEL_P;
                cmd.acc_clr = 1'b1;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lfps_pkg::MUL_SEL_I;
                cmd.acc_add = 1'b1;
                state_next  = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = lfps_pkg::MUL_SEL_D;
                cmd.acc_add = 1'b1;
                state_next  = ST_ACC_D;
            end
            ST_ACC_D: begin
                cmd.acc_add = 1'b1;
                state_next  = ST_DIV_INIT;
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `LFPS_ASSERT_IMPLY(a_load_only_when_free, cmd.out_load, status.out_free)
    `LFPS_ASSERT_NEXT(a_div_ends_in_out, state_reg == ST_DIV, state_reg == ST_OUT)

endmodule

FILE: rtl/lfps_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lfps_datapath #(
    parameter int VOTE_WINDOW = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lfps_pkg::cmd_t       cmd,
    output lfps_pkg::status_t    status,
    input  lfps_pkg::sensors_t   s_raw_sensors,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  lfps_pkg::cfg_idx_t   cfg_index,
    input  lfps_pkg::cfg_data_t  cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output lfps_pkg::steer_t     m_steer,
    output lfps_pkg::sensors_t   m_voted_sensors,
    output lfps_pkg::class_t     m_pattern_class
);

    localparam int SLOT_W = (VOTE_WINDOW > 1) ? $clog2(VOTE_WINDOW) : 1;
    localparam int CNT_W  = $clog2(VOTE_WINDOW + 1);
    localparam int NSENS  = lfps_pkg::SENSOR_W;
    localparam int SUM_W  = lfps_pkg::INTEG_W + 1;

    // configuration registers
    lfps_pkg::gain_t  gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    lfps_pkg::limit_t integral_limit_reg;

    // sample history and per-bit running counts
    lfps_pkg::sensors_t sample_ring_reg [VOTE_WINDOW];
    logic [SLOT_W-1:0]  ring_slot_reg, ring_slot_next;
    logic [CNT_W-1:0]   bit_cnt_reg [NSENS];
    logic [CNT_W-1:0]   bit_cnt_next [NSENS];
    lfps_pkg::sensors_t ring_old;

    // classification
    lfps_pkg::sensors_t voted;
    lfps_pkg::err_t     err_sel;
    lfps_pkg::class_t   cls_sel;
    logic               skip_sel, clr_sel, left_set;
    lfps_pkg::sensors_t voted_reg;
    lfps_pkg::class_t   cls_reg;
    lfps_pkg::err_t     err_reg;
    logic               skip_reg, integ_clr_reg, left_turn_reg;

    // PID state
    lfps_pkg::integ_t   integ_reg, integ_next;
    lfps_pkg::err_t     prev_err_reg;
    lfps_pkg::deriv_t   deriv_reg, deriv_next;
    logic signed [SUM_W-1:0] integ_base, integ_sum, integ_clip, lim_pos, lim_neg;

    // multiply-accumulate
    logic signed [lfps_pkg::GAIN_W:0]    mul_gain;
    lfps_pkg::integ_t                    mul_op;
    logic signed [lfps_pkg::MUL_W-1:0]   mul_full;
    lfps_pkg::acc_t                      prod_reg, acc_reg;

    // divide
    lfps_pkg::acc_t     div_mag;
    logic               neg_reg, sat_reg;
    lfps_pkg::scaled_t  scaled_reg;
    lfps_pkg::rprod_t   recip_full;
    lfps_pkg::quot_t    quot_reg;

    // output stage
    logic               m_valid_reg;
    lfps_pkg::steer_t   steer_sel, steer_reg, quot_ext;
    lfps_pkg::sensors_t m_voted_reg;
    lfps_pkg::class_t   m_class_reg;

    // write configuration, ignore unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg      <= '0;
            gain_integ_reg     <= '0;
            gain_deriv_reg     <= '0;
            integral_limit_reg <= lfps_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                lfps_pkg::REG_GAIN_PROP:
                    gain_prop_reg <= cfg_data[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_GAIN_INTEG:
                    gain_integ_reg <= cfg_data[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_GAIN_DERIV:
                    gain_deriv_reg <= cfg_data[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_INTEGRAL_LIMIT:
                    integral_limit_reg <= cfg_data[lfps_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // update running counts by the entry being replaced
    always_comb begin
        ring_old = sample_ring_reg[ring_slot_reg];
        ring_slot_next = (ring_slot_reg == SLOT_W'(VOTE_WINDOW - 1)) ?
                         '0 : ring_slot_reg + SLOT_W'(1);
        for (int b = 0; b < NSENS; b++) begin
            bit_cnt_next[b] = bit_cnt_reg[b];
            if (s_raw_sensors[b] && !ring_old[b]) begin
                bit_cnt_next[b] = bit_cnt_reg[b] + CNT_W'(1);
            end else if (!s_raw_sensors[b] && ring_old[b]) begin
                bit_cnt_next[b] = bit_cnt_reg[b] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < VOTE_WINDOW; k++) begin
                sample_ring_reg[k] <= '0;
            end
            for (int b = 0; b < NSENS; b++) begin
                bit_cnt_reg[b] <= '0;
            end
            ring_slot_reg <= '0;
        end else if (cmd.accept) begin
            sample_ring_reg[ring_slot_reg] <= s_raw_sensors;
            bit_cnt_reg   <= bit_cnt_next;
            ring_slot_reg <= ring_slot_next;
        end
    end

    // majority vote and pattern decode
    always_comb begin
        for (int b = 0; b < NSENS; b++) begin
            voted[b] = (bit_cnt_reg[b] > CNT_W'(VOTE_WINDOW / 2));
        end
        err_sel  = '0;
        cls_sel  = lfps_pkg::CLS_WEIGHTED;
        skip_sel = 1'b0;
        clr_sel  = 1'b0;
        left_set = 1'b0;
        unique case (voted) inside
            lfps_pkg::PAT_ALL_BLACK: begin
                cls_sel  = lfps_pkg::CLS_ALL_BLACK;
                skip_sel = 1'b1;
            end
            lfps_pkg::PAT_ALL_WHITE: begin
                cls_sel  = lfps_pkg::CLS_ALL_WHITE;
                skip_sel = 1'b1;
            end
            lfps_pkg::PAT_CENTER: begin
                cls_sel = lfps_pkg::CLS_CENTER;
                clr_sel = 1'b1;
            end
            lfps_pkg::PAT_SLIGHT_L: begin
                cls_sel = lfps_pkg::CLS_SLIGHT;
                err_sel = -lfps_pkg::ERR_SLIGHT;
            end
            lfps_pkg::PAT_SLIGHT_R: begin
                cls_sel = lfps_pkg::CLS_SLIGHT;
                err_sel = lfps_pkg::ERR_SLIGHT;
            end
            lfps_pkg::PAT_LEFT3: begin
                cls_sel  = lfps_pkg::CLS_STRONG;
                err_sel  = -lfps_pkg::ERR_STRONG;
                clr_sel  = !left_turn_reg;
                left_set = 1'b1;
            end
            lfps_pkg::PAT_RIGHT3, lfps_pkg::PAT_RIGHT2: begin
                cls_sel = lfps_pkg::CLS_STRONG;
                err_sel = lfps_pkg::ERR_STRONG;
            end
            lfps_pkg::PAT_LEFT2: begin
                cls_sel = lfps_pkg::CLS_STRONG;
                err_sel = -lfps_pkg::ERR_STRONG;
            end
            default: begin
                err_sel = lfps_pkg::weighted_error(voted);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.classify) begin
            voted_reg     <= voted;
            cls_reg       <= cls_sel;
            err_reg       <= err_sel;
            skip_reg      <= skip_sel;
            integ_clr_reg <= clr_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_turn_reg <= 1'b0;
        end else if (cmd.classify && left_set) begin
            left_turn_reg <= 1'b1;
        end
    end

    // accumulate error and clamp to the symmetric limit
    always_comb begin
        lim_pos    = SUM_W'({integral_limit_reg, 4'b0000});
        lim_neg    = -lim_pos;
        integ_base = integ_clr_reg ? '0 : SUM_W'(integ_reg);
        integ_sum  = integ_base + SUM_W'(err_reg);
        integ_clip = (integ_sum >= lim_pos) ? lim_pos : integ_sum;
        integ_clip = (integ_clip <= lim_neg) ? lim_neg : integ_clip;
        integ_next = integ_clip[lfps_pkg::INTEG_W-1:0];
        deriv_next = lfps_pkg::DERIV_W'(err_reg) - lfps_pkg::DERIV_W'(prev_err_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end else if (cmd.integrate && !skip_reg) begin
            integ_reg    <= integ_next;
            prev_err_reg <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.integrate) begin
            deriv_reg <= deriv_next;
        end
    end

    // shared gain multiplier, one term per cycle
    always_comb begin
        case (cmd.mul_sel)
            lfps_pkg::MUL_SEL_P: begin
                mul_gain = $signed({1'b0, gain_prop_reg});
                mul_op   = lfps_pkg::INTEG_W'(err_reg);
            end
            lfps_pkg::MUL_SEL_I: begin
                mul_gain = $signed({1'b0, gain_integ_reg});
                mul_op   = integ_reg;
            end
            lfps_pkg::MUL_SEL_D: begin
                mul_gain = $signed({1'b0, gain_deriv_reg});
                mul_op   = lfps_pkg::INTEG_W'(deriv_reg);
            end
            default: begin
                mul_gain = '0;
                mul_op   = '0;
            end
        endcase
    end

    assign mul_full = mul_gain * mul_op;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= mul_full[lfps_pkg::ACC_W-1:0];
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    // divide the magnitude by the fixed scale: shift out 64, multiply by 1/25
    assign div_mag    = acc_reg[lfps_pkg::ACC_W-1] ? -acc_reg : acc_reg;
    assign recip_full = scaled_reg * lfps_pkg::RECIP_25;

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            neg_reg    <= acc_reg[lfps_pkg::ACC_W-1];
            sat_reg    <= ($unsigned(div_mag) >= $unsigned(lfps_pkg::SAT_MAG));
            scaled_reg <= div_mag[lfps_pkg::PRE_SHIFT +: lfps_pkg::SCALED_W];
        end
        if (cmd.div_step) begin
            quot_reg <= recip_full[lfps_pkg::RECIP_SHIFT +: lfps_pkg::QUOT_W];
        end
    end

    // pick the signed, saturated steering value
    always_comb begin
        quot_ext = $signed({1'b0, quot_reg});
        if (skip_reg) begin
            steer_sel = '0;
        end else if (sat_reg) begin
            steer_sel = neg_reg ? lfps_pkg::STEER_MIN : lfps_pkg::STEER_MAX;
        end else begin
            steer_sel = neg_reg ? -quot_ext : quot_ext;
        end
    end

    // output register: load a result, drop valid once the beat is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            steer_reg   <= steer_sel;
            m_voted_reg <= voted_reg;
            m_class_reg <= cls_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_steer         = steer_reg;
    assign m_voted_sensors = m_voted_reg;
    assign m_pattern_class = m_class_reg;

    assign status.skip     = skip_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    `LFPS_ASSERT_NEXT(a_integ_in_limit, cmd.integrate && !skip_reg,
        (SUM_W'(integ_reg) <= $past(lim_pos)) && (SUM_W'(integ_reg) >= $past(lim_neg)))
    `LFPS_ASSERT_NEXT(a_skip_gives_zero, cmd.out_load && skip_reg, m_steer == '0)
    `LFPS_ASSERT_NEXT(a_sat_hits_rail, cmd.out_load && !skip_reg && sat_reg,
        (m_steer == lfps_pkg::STEER_MAX) || (m_steer == lfps_pkg::STEER_MIN))

endmodule

FILE: rtl/line_follow_pid_steering.sv
`timescale 1ns / 1ps
// Line follower steering: five line-sensor bits in, one steering word out.
// Input beat (s_valid/s_ready, s_raw_sensors) is one sensor sample per tick while s_ready is high.
// Each beat produces exactly one result beat (m_valid/m_ready) carrying the
// saturated steering drive, the majority-voted sensor bits and the pattern
// class. Gains and the integral limit are written on the cfg_* channel,
// which is always ready; write them only while no sample is in flight.
// After the sample beat is taken the controller steps through classify,
// integrate, the three gain multiplies, the final add, the divide set-up and
// the divide step, then loads the output register; all-black and all-white
// patterns go from integrate straight to the output load. The shared gain
// multiplier forms three terms, one per cycle, plus the final add; the divide
// by the fixed output scale runs as magnitude and shift, then a reciprocal multiply.
// A new sample is taken as soon as the previous one has been loaded into the
// output register, even if that result is still waiting on m_ready; a held
// result stalls the next load, and the input then waits until that load is done.
// Reset clears the sample history, the integral, the previous error, the
// left-turn flag and the gains, and sets the integral limit to 1000.
module line_follow_pid_steering #(
    parameter int VOTE_WINDOW = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lfps_pkg::sensors_t  s_raw_sensors,
    output logic                m_valid,
    input  logic                m_ready,
    output lfps_pkg::steer_t    m_steer,
    output lfps_pkg::sensors_t  m_voted_sensors,
    output lfps_pkg::class_t    m_pattern_class,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  lfps_pkg::cfg_idx_t  cfg_index,
    input  lfps_pkg::cfg_data_t cfg_data
);

    lfps_pkg::cmd_t    cmd;
    lfps_pkg::status_t status;

    lfps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lfps_datapath #(
        .VOTE_WINDOW (VOTE_WINDOW)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_raw_sensors   (s_raw_sensors),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_steer         (m_steer),
        .m_voted_sensors (m_voted_sensors),
        .m_pattern_class (m_pattern_class)
    );

endmodule
